@@ design/mpea_pkg.sv @@
// shared types, codes and constants of the mpe channel allocator
`default_nettype none
package mpea_pkg;

	localparam int NUM_SLOTS_DEF = 15;

	// input modes
	localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
	localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
	localparam logic [1:0] MODE_OTHER    = 2'd2;
	localparam logic [1:0] MODE_FLUSH    = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_BEND     = 2'd0;
	localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
	localparam logic [1:0] KIND_NOTE_OFF = 2'd2;
	localparam logic [1:0] KIND_PASS     = 2'd3;

	localparam logic [13:0] BEND_CENTRE = 14'd8192;
	localparam logic [13:0] BEND_MAX    = 14'd16383;
	localparam logic [6:0]  RANGE_RESET = 7'd48;
	localparam logic [4:0]  MANAGER_CH  = 5'd1;

	// serial divider widths: (2*dev*128 + den) / (2*den), den = range*25
	localparam int DIVIDEND_W = 24;
	localparam int DIVISOR_W  = 13;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  channel;
		logic [7:0]  status;
		logic [6:0]  data1;
		logic [6:0]  data2;
		logic [13:0] bend;
		logic        last;
	} out_rec_t;

endpackage
`default_nettype wire

@@ design/mpea_divider.sv @@
// restoring serial divider, one quotient bit per cycle
`default_nettype none
module mpea_divider (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [mpea_pkg::DIVIDEND_W-1:0] dividend,
	input  wire logic [mpea_pkg::DIVISOR_W-1:0]  divisor,
	output logic                                 busy,
	output logic [mpea_pkg::DIVIDEND_W-1:0]      quotient
);
	import mpea_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    trial;
	logic                  ge;
	logic [DIVISOR_W:0]    diff;

	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIVIDEND_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

@@ design/mpe_channel_allocator_with_bend.sv @@
// mpe voice channel allocator: slot sequencer, bend arithmetic, output register
// Input channel (in_valid/in_stall) takes one MIDI event: a note on, a note off,
// another message or an all-notes-off. Results leave on the output channel
// (out_valid/out_stall), one per transfer, with last set on the final one.
// A note on scans the slots round robin, one slot per cycle, while a serial
// divider forms the pitch bend, one quotient bit per cycle: the bend result
// leaves once the divider is done, the note on follows it, and the next event
// is taken after the note on. A note off scans up to NUM_SLOTS slots and, if it
// finds the note, gives a note off and a centre bend. An
// all-notes-off walks every slot and gives two results per active one.
// in_stall is high while an event is in work; one finished result may wait in
// the output register while the next event is taken. A stall on the output
// holds the result and stops the sequencer at its next result.
// Reset frees all slots, sets the round-robin pointer to slot 0 and the bend
// range to 48 semitones. bend_range is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while the block is idle; the block does not enforce it.
`default_nettype none
module mpe_channel_allocator_with_bend #(
	parameter int NUM_SLOTS = mpea_pkg::NUM_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [6:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  status_byte,
	input  wire logic [6:0]  note_or_data1,
	input  wire logic [6:0]  velocity_or_data2,
	input  wire logic [15:0] cents_deviation,
	input  wire logic [15:0] sample_pos,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [4:0]       channel,
	output logic [7:0]       out_status,
	output logic [6:0]       out_data1,
	output logic [6:0]       out_data2,
	output logic [13:0]      bend_value,
	output logic [15:0]      out_sample_pos,
	output logic             last
);
	import mpea_pkg::*;

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

	localparam logic [3:0] ST_IDLE       = 4'd0;
	localparam logic [3:0] ST_ON_SCAN    = 4'd1;
	localparam logic [3:0] ST_ON_BEND    = 4'd2;
	localparam logic [3:0] ST_ON_NOTE    = 4'd3;
	localparam logic [3:0] ST_OFF_SCAN   = 4'd4;
	localparam logic [3:0] ST_OFF_NOTE   = 4'd5;
	localparam logic [3:0] ST_OFF_BEND   = 4'd6;
	localparam logic [3:0] ST_PASS       = 4'd7;
	localparam logic [3:0] ST_FLUSH_SCAN = 4'd8;
	localparam logic [3:0] ST_FLUSH_OFF  = 4'd9;
	localparam logic [3:0] ST_FLUSH_BEND = 4'd10;

	logic [3:0]           state_q;
	logic [6:0]           range_q;
	logic [NUM_SLOTS-1:0] slot_active_q;
	logic [6:0]           slot_note_q [NUM_SLOTS];
	logic [SW-1:0]        next_slot_q;
	logic [SW-1:0]        scan_q;
	logic [SW-1:0]        cnt_q;
	logic [SW-1:0]        alloc_q;

	// latched event
	logic [7:0]  status_q;
	logic [6:0]  data1_q;
	logic [6:0]  data2_q;
	logic        neg_q;
	logic [15:0] pos_q;

	out_rec_t    out_q;
	logic        out_valid_q;
	logic [15:0] out_pos_q;

	logic                  in_xfer;
	logic                  out_free;
	logic                  emit_en;
	out_rec_t              emit_rec;
	logic                  scan_free;
	logic                  scan_hit;
	logic [SW-1:0]         scan_wrap;
	logic [SW-1:0]         steal_wrap;
	logic [4:0]            scan_ch;
	logic [4:0]            alloc_ch;
	logic [15:0]           dev_mag;
	logic [11:0]           den;
	logic [DIVIDEND_W-1:0] dividend;
	logic                  div_start;
	logic                  div_busy;
	logic [DIVIDEND_W-1:0] quo;
	logic [13:0]           bend_calc;
	logic [7:0]            pass_status;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		scan_free  = !slot_active_q[scan_q];
		scan_hit   = slot_active_q[scan_q] && (slot_note_q[scan_q] == data1_q);
		scan_wrap  = (scan_q == LAST_SLOT) ? '0 : scan_q + 1'b1;
		steal_wrap = (next_slot_q == LAST_SLOT) ? '0 : next_slot_q + 1'b1;
		scan_ch    = 5'(scan_q) + 5'd2;
		alloc_ch   = 5'(alloc_q) + 5'd2;
	end

	// bend divider operands, formed from the deviation port and the bend range at the note-on transfer
	always_comb begin
		dev_mag   = cents_deviation[15] ? (~cents_deviation + 16'd1) : cents_deviation;
		den       = {1'b0, range_q, 4'b0} + {2'b0, range_q, 3'b0} + {5'b0, range_q};
		dividend  = {dev_mag, 8'b0} + {12'b0, den};
		div_start = in_xfer && (mode == MODE_NOTE_ON);
	end

	mpea_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  ({den, 1'b0}),
		.busy     (div_busy),
		.quotient (quo)
	);

	// clamp the bend to 0..16383 around centre; form the passthrough status
	always_comb begin
		if (range_q == '0) begin
			bend_calc = BEND_CENTRE;
		end else if (!neg_q) begin
			bend_calc = (quo > DIVIDEND_W'(8191)) ? BEND_MAX : BEND_CENTRE + quo[13:0];
		end else begin
			bend_calc = (quo >= DIVIDEND_W'(8192)) ? '0 : BEND_CENTRE - quo[13:0];
		end
		pass_status = (status_q[7] && (status_q[7:4] != 4'hF)) ? {status_q[7:4], 4'h0}
			: status_q;
	end

	always_comb begin
		emit_en  = 1'b0;
		emit_rec = '0;
		unique case (state_q)
			ST_ON_BEND: begin
				emit_en          = out_free && !div_busy;
				emit_rec.kind    = KIND_BEND;
				emit_rec.channel = alloc_ch;
				emit_rec.bend    = bend_calc;
			end
			ST_ON_NOTE: begin
				emit_en          = out_free;
				emit_rec.kind    = KIND_NOTE_ON;
				emit_rec.channel = alloc_ch;
				emit_rec.data1   = data1_q;
				emit_rec.data2   = data2_q;
				emit_rec.last    = 1'b1;
			end
			ST_OFF_NOTE: begin
				emit_en          = out_free;
				emit_rec.kind    = KIND_NOTE_OFF;
				emit_rec.channel = scan_ch;
				emit_rec.data1   = data1_q;
				emit_rec.data2   = data2_q;
			end
			ST_OFF_BEND: begin
				emit_en          = out_free;
				emit_rec.kind    = KIND_BEND;
				emit_rec.channel = scan_ch;
				emit_rec.bend    = BEND_CENTRE;
				emit_rec.last    = 1'b1;
			end
			ST_PASS: begin
				emit_en          = out_free;
				emit_rec.kind    = KIND_PASS;
				emit_rec.channel = MANAGER_CH;
				emit_rec.status  = pass_status;
				emit_rec.data1   = data1_q;
				emit_rec.data2   = data2_q;
				emit_rec.last    = 1'b1;
			end
			ST_FLUSH_OFF: begin
				emit_en          = out_free;
				emit_rec.kind    = KIND_NOTE_OFF;
				emit_rec.channel = scan_ch;
				emit_rec.data1   = slot_note_q[scan_q];
			end
			ST_FLUSH_BEND: begin
				// slot already freed, so last when nothing else is held
				emit_en          = out_free;
				emit_rec.kind    = KIND_BEND;
				emit_rec.channel = scan_ch;
				emit_rec.bend    = BEND_CENTRE;
				emit_rec.last    = ~|slot_active_q;
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	// sequencer and slot table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			range_q       <= RANGE_RESET;
			slot_active_q <= '0;
			slot_note_q   <= '{default: '0};
			next_slot_q   <= '0;
			scan_q        <= '0;
			cnt_q         <= '0;
			alloc_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				range_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cnt_q <= '0;
						unique case (mode)
							MODE_NOTE_ON: begin
								scan_q  <= next_slot_q;
								state_q <= ST_ON_SCAN;
							end
							MODE_NOTE_OFF: begin
								scan_q  <= '0;
								state_q <= ST_OFF_SCAN;
							end
							MODE_OTHER: begin
								state_q <= ST_PASS;
							end
							MODE_FLUSH: begin
								scan_q  <= '0;
								state_q <= ST_FLUSH_SCAN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ON_SCAN: begin
					if (scan_free) begin
						alloc_q                <= scan_q;
						slot_active_q[scan_q]  <= 1'b1;
						slot_note_q[scan_q]    <= data1_q;
						next_slot_q            <= scan_wrap;
						state_q                <= ST_ON_BEND;
					end else if (cnt_q == LAST_SLOT) begin
						// all busy: steal the pointer slot
						alloc_q                    <= next_slot_q;
						slot_note_q[next_slot_q]   <= data1_q;
						next_slot_q                <= steal_wrap;
						state_q                    <= ST_ON_BEND;
					end else begin
						scan_q <= scan_wrap;
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				ST_ON_BEND: begin
					if (emit_en) begin
						state_q <= ST_ON_NOTE;
					end
				end
				ST_ON_NOTE, ST_OFF_BEND, ST_PASS: begin
					if (emit_en) begin
						state_q <= ST_IDLE;
					end
				end
				ST_OFF_SCAN: begin
					if (scan_hit) begin
						state_q <= ST_OFF_NOTE;
					end else if (scan_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end else begin
						scan_q <= scan_wrap;
					end
				end
				ST_OFF_NOTE: begin
					if (emit_en) begin
						slot_active_q[scan_q] <= 1'b0;
						slot_note_q[scan_q]   <= '0;
						state_q               <= ST_OFF_BEND;
					end
				end
				ST_FLUSH_SCAN: begin
					if (slot_active_q[scan_q]) begin
						state_q <= ST_FLUSH_OFF;
					end else if (scan_q == LAST_SLOT) begin
						next_slot_q <= '0;
						state_q     <= ST_IDLE;
					end else begin
						scan_q <= scan_wrap;
					end
				end
				ST_FLUSH_OFF: begin
					if (emit_en) begin
						slot_active_q[scan_q] <= 1'b0;
						slot_note_q[scan_q]   <= '0;
						state_q               <= ST_FLUSH_BEND;
					end
				end
				ST_FLUSH_BEND: begin
					if (emit_en) begin
						if (scan_q == LAST_SLOT) begin
							next_slot_q <= '0;
							state_q     <= ST_IDLE;
						end else begin
							scan_q  <= scan_wrap;
							state_q <= ST_FLUSH_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			status_q <= status_byte;
			data1_q  <= note_or_data1;
			data2_q  <= velocity_or_data2;
			neg_q    <= cents_deviation[15];
			pos_q    <= sample_pos;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			out_q     <= emit_rec;
			out_pos_q <= pos_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = out_q.kind;
	assign channel        = out_q.channel;
	assign out_status     = out_q.status;
	assign out_data1      = out_q.data1;
	assign out_data2      = out_q.data2;
	assign bend_value     = out_q.bend;
	assign out_sample_pos = out_pos_q;
	assign last           = out_q.last;

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// testbench for the mpe channel allocator: directed and random midi events checked against a predictor
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mpea_pkg::*;

	localparam int NSLOT          = NUM_SLOTS_DEF;
	localparam int SETTLE_CYCLES  = 64;
	localparam int HOLD_CYCLES    = 250;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  channel;
		logic [7:0]  status;
		logic [6:0]  data1;
		logic [6:0]  data2;
		logic [13:0] bend;
		logic [15:0] pos;
		logic        last;
	} midi_msg_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [6:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [7:0]  status_byte;
	logic [6:0]  note_or_data1;
	logic [6:0]  velocity_or_data2;
	logic [15:0] cents_deviation;
	logic [15:0] sample_pos;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [4:0]  channel;
	logic [7:0]  out_status;
	logic [6:0]  out_data1;
	logic [6:0]  out_data2;
	logic [13:0] bend_value;
	logic [15:0] out_sample_pos;
	logic        last;

	// predictor state
	logic [6:0]  slot_note [NSLOT];
	bit          slot_busy [NSLOT];
	int          rr_ptr;
	logic [6:0]  bend_range;
	midi_msg_t   pending_msgs [$];

	int  mismatches;
	int  events_sent;
	int  results_checked;
	int  steal_count;
	int  range_writes;
	int  idle_cycles;
	int  hold_left;
	bit  tx_quiet;
	bit  rx_quiet;

	mpe_channel_allocator_with_bend #(.NUM_SLOTS(NSLOT)) u_dut (.*);

	always #5 clk = ~clk;

	function automatic logic [13:0] tuned_bend(logic signed [15:0] dev, logic [6:0] rng);
		longint mag, num, den, q, v;
		if (rng == 7'd0)
			return BEND_CENTRE;
		mag = (dev < 0) ? -longint'(dev) : longint'(dev);
		num = mag * 128;
		den = longint'(rng) * 25;
		// rounded half away from zero
		q = (2 * num + den) / (2 * den);
		v = (dev < 0) ? longint'(BEND_CENTRE) - q : longint'(BEND_CENTRE) + q;
		if (v < 0)
			v = 0;
		if (v > longint'(BEND_MAX))
			v = longint'(BEND_MAX);
		return v[13:0];
	endfunction

	function automatic void queue_msg(logic [1:0] k, logic [4:0] ch, logic [7:0] st,
			logic [6:0] d1, logic [6:0] d2, logic [13:0] b, logic [15:0] pos);
		pending_msgs.push_back('{k, ch, st, d1, d2, b, pos, 1'b0});
	endfunction

	function automatic void predict_midi_out(logic [1:0] md, logic [7:0] st, logic [6:0] d1,
			logic [6:0] d2, logic [15:0] dev, logic [15:0] pos);
		int n, idx, k;
		bit found;
		n = 0;
		case (md)
			MODE_NOTE_ON: begin
				idx = -1;
				for (k = 0; k < NSLOT; k++)
					if (idx < 0 && !slot_busy[(rr_ptr + k) % NSLOT])
						idx = (rr_ptr + k) % NSLOT;
				// all busy: the voice at the pointer is stolen without a note off
				if (idx < 0) begin
					idx = rr_ptr;
					steal_count++;
				end
				slot_busy[idx] = 1'b1;
				slot_note[idx] = d1;
				rr_ptr = (idx + 1) % NSLOT;
				queue_msg(KIND_BEND, 5'(idx + 2), 8'd0, 7'd0, 7'd0,
					tuned_bend($signed(dev), bend_range), pos);
				queue_msg(KIND_NOTE_ON, 5'(idx + 2), 8'd0, d1, d2, 14'd0, pos);
				n = 2;
			end
			MODE_NOTE_OFF: begin
				found = 1'b0;
				for (k = 0; k < NSLOT; k++)
					if (!found && slot_busy[k] && slot_note[k] == d1) begin
						found = 1'b1;
						slot_busy[k] = 1'b0;
						slot_note[k] = 7'd0;
						queue_msg(KIND_NOTE_OFF, 5'(k + 2), 8'd0, d1, d2, 14'd0, pos);
						queue_msg(KIND_BEND, 5'(k + 2), 8'd0, 7'd0, 7'd0, BEND_CENTRE, pos);
						n = 2;
					end
			end
			MODE_OTHER: begin
				queue_msg(KIND_PASS, MANAGER_CH,
					(st >= 8'h80 && st < 8'hF0) ? {st[7:4], 4'h0} : st, d1, d2, 14'd0, pos);
				n = 1;
			end
			default: begin
				for (k = 0; k < NSLOT; k++)
					if (slot_busy[k]) begin
						queue_msg(KIND_NOTE_OFF, 5'(k + 2), 8'd0, slot_note[k], 7'd0, 14'd0, pos);
						queue_msg(KIND_BEND, 5'(k + 2), 8'd0, 7'd0, 7'd0, BEND_CENTRE, pos);
						slot_busy[k] = 1'b0;
						slot_note[k] = 7'd0;
						n += 2;
					end
				rr_ptr = 0;
			end
		endcase
		if (n > 0)
			pending_msgs[pending_msgs.size() - 1].last = 1'b1;
	endfunction

	function automatic string show_msg(midi_msg_t m);
		return $sformatf("kind=%0d ch=%0d status=%02h d1=%0d d2=%0d bend=%0d pos=%0d last=%0b",
			m.kind, m.channel, m.status, m.data1, m.data2, m.bend, m.pos, m.last);
	endfunction

	task automatic note_failure(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, what);
	endtask

	// result checker
	always @(posedge clk) begin
		midi_msg_t act_m, exp_m;
		if (arst_n && out_valid && !out_stall) begin
			act_m = '{kind, channel, out_status, out_data1, out_data2, bend_value,
				out_sample_pos, last};
			if (pending_msgs.size() == 0) begin
				note_failure({"result with nothing expected: ", show_msg(act_m)});
			end else begin
				exp_m = pending_msgs.pop_front();
				results_checked++;
				if (act_m !== exp_m)
					note_failure({"mismatch\n  expected ", show_msg(exp_m),
						"\n  actual   ", show_msg(act_m)});
			end
		end
	end

	// receiver stall, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= !rx_quiet && ($urandom_range(99) < 22);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
					idle_cycles, pending_msgs.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_event(input logic [1:0] md, input logic [7:0] st, input logic [6:0] d1,
			input logic [6:0] d2, input logic [15:0] dev, input logic [15:0] pos);
		@(negedge clk);
		while (!tx_quiet && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid          <= 1'b1;
		mode              <= md;
		status_byte       <= st;
		note_or_data1     <= d1;
		velocity_or_data2 <= d2;
		cents_deviation   <= dev;
		sample_pos        <= pos;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_midi_out(md, st, d1, d2, dev, pos);
		events_sent++;
	endtask

	function automatic logic [15:0] random_dev();
		if ($urandom_range(9) < 7)
			return 16'($urandom_range(65535));
		return 16'($urandom_range(400) - 200);
	endfunction

	task automatic send_note_on(logic [6:0] note, logic [6:0] vel, logic [15:0] dev);
		send_event(MODE_NOTE_ON, 8'($urandom_range(255)), note, vel, dev, 16'($urandom_range(65535)));
	endtask

	task automatic send_note_off(logic [6:0] note, logic [6:0] vel);
		send_event(MODE_NOTE_OFF, 8'($urandom_range(255)), note, vel, random_dev(),
			16'($urandom_range(65535)));
	endtask

	task automatic send_pass(logic [7:0] st);
		send_event(MODE_OTHER, st, 7'($urandom_range(127)), 7'($urandom_range(127)),
			random_dev(), 16'($urandom_range(65535)));
	endtask

	task automatic send_flush();
		send_event(MODE_FLUSH, 8'($urandom_range(255)), 7'($urandom_range(127)),
			7'($urandom_range(127)), random_dev(), 16'($urandom_range(65535)));
	endtask

	// sender pause: drop valid, wait for every expected result and let the block settle
	task automatic wait_all_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_msgs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_bend_range(logic [6:0] rng);
		wait_all_results();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= rng;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		bend_range = rng;
		range_writes++;
	endtask

	task automatic test_directed();
		send_event(MODE_OTHER, 8'h00, 7'd0, 7'd0, 16'h0000, 16'h0000);
		send_event(MODE_OTHER, 8'h7F, 7'd127, 7'd127, 16'hFFFF, 16'hFFFF);
		// channel messages lose their channel nibble, system messages pass whole
		send_pass(8'h80);
		send_pass(8'h9F);
		send_pass(8'hEF);
		send_pass(8'hF0);
		send_pass(8'hFF);
		send_note_off(7'd60, 7'd64);
		send_flush();
		send_event(MODE_NOTE_ON, 8'h00, 7'd0, 7'd0, 16'h8000, 16'hFFFF);
		send_event(MODE_NOTE_ON, 8'hFF, 7'd127, 7'd127, 16'h7FFF, 16'h0000);
		send_note_on(7'd60, 7'd64, 16'h0000);
		send_note_on(7'd61, 7'd1, 16'hFFFF);
		send_note_on(7'd62, 7'd100, 16'h0001);
		send_note_on(7'd60, 7'd90, 16'd100);
		send_note_off(7'd60, 7'd127);
		send_note_off(7'd60, 7'd0);
		send_note_off(7'd60, 7'd5);
		send_flush();
		send_note_on(7'd64, 7'd0, 16'hFF38);
		send_flush();
	endtask

	task automatic test_voice_steal();
		int i;
		for (i = 0; i < NSLOT + 2; i++)
			send_note_on(7'(10 + i), 7'($urandom_range(127)), random_dev());
		send_note_off(7'd10, 7'd64);
		send_note_off(7'd12, 7'd64);
		send_note_on(7'd40, 7'd80, random_dev());
		send_note_on(7'd41, 7'd81, random_dev());
		send_flush();
	endtask

	task automatic test_bend_range();
		logic [6:0] ranges [5];
		int r;
		ranges = '{7'd0, 7'd1, 7'd127, 7'h55, 7'h2A};
		for (r = 0; r < 5; r++) begin
			set_bend_range(ranges[r]);
			send_note_on(7'd50, 7'd100, 16'h8000);
			send_note_on(7'd51, 7'd100, 16'h7FFF);
			send_note_on(7'd52, 7'd100, 16'hFFFF);
			send_note_on(7'd53, 7'd100, 16'h0001);
			send_note_on(7'd54, 7'd100, random_dev());
			send_flush();
		end
	endtask

	task automatic test_backpressure();
		int i;
		set_bend_range(RANGE_RESET);
		hold_left = HOLD_CYCLES;
		for (i = 0; i < 20; i++) begin
			if (i % 3 == 2)
				send_pass(8'($urandom_range(255)));
			else
				send_note_on(7'($urandom_range(127)), 7'($urandom_range(127)), random_dev());
		end
		send_flush();
		wait_all_results();
		send_note_on(7'd70, 7'd70, random_dev());
		send_note_off(7'd70, 7'd10);
	endtask

	task automatic test_random();
		int ph, k, pick, j, s;
		bit found;
		logic [6:0] nt;
		for (ph = 0; ph < 4; ph++) begin
			set_bend_range(7'($urandom_range(127)));
			tx_quiet = (ph == 1);
			rx_quiet = (ph == 1);
			for (k = 0; k < 41; k++) begin
				if (ph == 2 && k == 20)
					wait_all_results();
				pick = $urandom_range(99);
				if (pick < 45) begin
					send_note_on(7'($urandom_range(127)), 7'($urandom_range(127)), random_dev());
				end else if (pick < 75) begin
					// mostly release a sounding note, sometimes a random one
					found = 1'b0;
					nt = 7'($urandom_range(127));
					s = $urandom_range(NSLOT - 1);
					if ($urandom_range(3) != 0)
						for (j = 0; j < NSLOT; j++)
							if (!found && slot_busy[(s + j) % NSLOT]) begin
								found = 1'b1;
								nt = slot_note[(s + j) % NSLOT];
							end
					send_note_off(nt, 7'($urandom_range(127)));
				end else if (pick < 92) begin
					send_pass(8'($urandom_range(255)));
				end else begin
					send_flush();
				end
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = 7'd0;
		in_valid          = 1'b0;
		mode              = MODE_OTHER;
		status_byte       = 8'd0;
		note_or_data1     = 7'd0;
		velocity_or_data2 = 7'd0;
		cents_deviation   = 16'd0;
		sample_pos        = 16'd0;
		foreach (slot_note[i]) begin
			slot_note[i] = 7'd0;
			slot_busy[i] = 1'b0;
		end
		rr_ptr     = 0;
		bend_range = RANGE_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_voice_steal();
		test_bend_range();
		test_backpressure();
		test_random();

		wait_all_results();
		if (pending_msgs.size() != 0)
			note_failure($sformatf("%0d expected results never arrived", pending_msgs.size()));
		$display("covered %0d midi events (%0d voice steals) and checked %0d results",
			events_sent, steal_count, results_checked);
		$display("bend range written %0d times, %0d mismatches", range_writes, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
